// ----- hw/rtl/bcps_pkg.sv -----
// ---------------------------------------------------------------------------
// bcps_pkg
// Types, codes and helper functions for the box collision pair scanner.
// ---------------------------------------------------------------------------
package bcps_pkg;

  localparam int DEFAULT_NUM_SLOTS = 8;
  localparam int MAX_RESULTS       = 28;
  localparam logic [8:0] MATRIX_RESET = 9'd160;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_MARK  = 2'd1;
  localparam logic [1:0] FUNC_FRAME = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [2:0] KIND_ASSIGNED = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_ACK      = 3'd2;
  localparam logic [2:0] KIND_PAIR     = 3'd3;
  localparam logic [2:0] KIND_DONE     = 3'd4;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]       rect_w;
    logic [14:0]       rect_h;
    logic [1:0]        box_type;
    logic              has_listener;
    logic [2:0]        slot_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] first_slot;
    logic [2:0] second_slot;
    logic       notify_first;
    logic       notify_second;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]       w;
    logic [14:0]       h;
    logic [1:0]        ctype;
    logic              listener;
  } box_t;

  typedef struct packed {
    logic valid;
    box_t box;
  } probe_t;

  typedef struct packed {
    logic hit;
    logic na;
    logic nb;
  } hit_t;

  function automatic logic reports(input logic [8:0] m, input logic [1:0] a,
                                   input logic [1:0] b);
    logic [3:0] idx;
    idx = 4'({2'b00, a}) * 4'd3 + 4'({2'b00, b});
    if (a > 2'd2 || b > 2'd2) return 1'b0;
    return m[idx];
  endfunction

  function automatic logic overlap(input box_t p, input box_t q);
    logic signed [16:0] pr, pb, qr, qb;
    pr = 17'(p.x) + $signed({2'b00, p.w});
    pb = 17'(p.y) + $signed({2'b00, p.h});
    qr = 17'(q.x) + $signed({2'b00, q.w});
    qb = 17'(q.y) + $signed({2'b00, q.h});
    if (qr < 17'(p.x) || qb < 17'(p.y) || 17'(q.x) > pr || 17'(q.y) > pb)
      return 1'b0;
    return 1'b1;
  endfunction

endpackage

// ----- hw/rtl/box_collision_pair_scanner_unit.sv -----
// ---------------------------------------------------------------------------
// box_collision_pair_scanner_unit
// Box table with all-pairs overlap scan over a chain of slot cells.
// ---------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one item: add, mark, frame, clear.
// Output channel out_valid/out_stall carries result items; the final one
// of each input item has last set. cfg_wen/cfg_wdata write the notify
// matrix; the user must write it only while the block is idle, as the
// block does not enforce this. Add, mark and clear give one registered
// result, valid in the cycle after acceptance. A frame walks a probe box
// down the cell chain, one pair test per cycle while the output is free:
// each occupied slot but the last loads its box as the probe into the
// next cell, and the probe is tested against every later slot in turn.
// Pair results are held one deep so the last flag can be set; the last
// one leaves when the walk ends.
// One item is in work at a time; a new one is taken when idle and the
// output register is free.
// A stalled output freezes the walk. Reset empties the table, clears all
// marks and loads the matrix with 160.
// ---------------------------------------------------------------------------
module box_collision_pair_scanner_unit import bcps_pkg::*; #(
  parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wen,
  input  logic [8:0] cfg_wdata
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(MAX_RESULTS + 1);

  state_t state, state_next;
  logic [8:0] matrix;
  logic [NUM_SLOTS-1:0] slot_valid, slot_doomed;
  logic [IW-1:0] i, probe_idx, free_idx, hit_idx;
  logic [CW-1:0] cnt;
  out_item_t pend;
  logic pend_valid;
  logic out_valid_next;
  out_item_t out_item_next;

  box_t   boxes  [NUM_SLOTS];
  probe_t pin    [NUM_SLOTS];
  probe_t pout   [NUM_SLOTS];
  hit_t   hits   [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pvalid, cwr;
  box_t   new_box;
  hit_t   hit;
  logic out_free, in_acc, busy, scan_step, scan_end, inject, take_hit, free_found;

  assign new_box = '{x: in_item.rect_x, y: in_item.rect_y, w: in_item.rect_w,
                     h: in_item.rect_h, ctype: in_item.box_type,
                     listener: in_item.has_listener};

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign pin[g] = '0;
      end else begin : g_body
        assign pin[g] = (inject && i == IW'(g - 1)) ? probe_t'{1'b1, boxes[i]}
                                                     : pout[g-1];
      end
      assign cwr[g]    = in_acc && in_item.func == FUNC_ADD && free_found &&
                         free_idx == IW'(g);
      assign pvalid[g] = pout[g].valid;
      bcps_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .wr        (cwr[g]),
        .wr_box    (new_box),
        .shift     (scan_step),
        .probe_in  (pin[g]),
        .matrix    (matrix),
        .occupied  (slot_valid[g]),
        .box       (boxes[g]),
        .probe_out (pout[g]),
        .hit       (hits[g])
      );
    end
  endgenerate

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit        = '0;
    hit_idx    = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (!slot_valid[k]) begin
        free_found = 1'b1;
        free_idx   = IW'(k);
      end
    end
    for (int k = 0; k < NUM_SLOTS; k++) begin
      hit = hit | hits[k];
      if (hits[k].hit) hit_idx = IW'(k);
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !(state == ST_IDLE && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign busy      = |pvalid;
  assign scan_step = state == ST_SCAN && out_free;
  assign scan_end  = scan_step && !busy && i == IW'(NUM_SLOTS - 1);
  assign inject    = scan_step && !busy && i != IW'(NUM_SLOTS - 1) && slot_valid[i];
  assign take_hit  = scan_step && hit.hit && cnt != CW'(MAX_RESULTS);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && in_item.func == FUNC_FRAME) state_next = ST_SCAN;
      ST_SCAN: if (scan_end) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    out_item_next  = out_item;
    if (in_acc) begin
      unique case (in_item.func)
        FUNC_ADD: begin
          out_valid_next = 1'b1;
          if (free_found)
            out_item_next = '{kind: KIND_ASSIGNED, first_slot: 3'(free_idx),
                              last: 1'b1, default: '0};
          else
            out_item_next = '{kind: KIND_FULL, last: 1'b1, default: '0};
        end
        FUNC_MARK, FUNC_CLEAR: begin
          out_valid_next = 1'b1;
          out_item_next  = '{kind: KIND_ACK, last: 1'b1, default: '0};
        end
        FUNC_FRAME: ;
        default: ;
      endcase
    end
    if (take_hit && pend_valid) begin
      out_valid_next = 1'b1;
      out_item_next  = pend;
    end
    if (scan_end) begin
      out_valid_next = 1'b1;
      if (pend_valid) begin
        out_item_next      = pend;
        out_item_next.last = 1'b1;
      end else begin
        out_item_next = '{kind: KIND_DONE, last: 1'b1, default: '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix      <= MATRIX_RESET;
      slot_valid  <= '0;
      slot_doomed <= '0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      i           <= '0;
      cnt         <= '0;
    end else begin
      if (cfg_wen) matrix <= cfg_wdata;
      out_valid <= out_valid_next;
      out_item  <= out_item_next;
      if (in_acc) begin
        unique case (in_item.func)
          FUNC_ADD: begin
            if (free_found) begin
              slot_valid[free_idx]  <= 1'b1;
              slot_doomed[free_idx] <= 1'b0;
            end
          end
          FUNC_MARK: begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
              if (32'(in_item.slot_index) == k && slot_valid[k])
                slot_doomed[k] <= 1'b1;
            end
          end
          FUNC_CLEAR: begin
            slot_valid  <= '0;
            slot_doomed <= '0;
          end
          FUNC_FRAME: begin
            slot_valid  <= slot_valid & ~slot_doomed;
            slot_doomed <= '0;
            i           <= '0;
            cnt         <= '0;
            pend_valid  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (scan_step && !busy && !scan_end) begin
        i <= i + IW'(1);
        if (inject) probe_idx <= i;
      end
      if (take_hit) begin
        pend <= '{kind: KIND_PAIR, first_slot: 3'(probe_idx),
                  second_slot: 3'(hit_idx), notify_first: hit.na,
                  notify_second: hit.nb, last: 1'b0};
        pend_valid <= 1'b1;
        cnt <= cnt + CW'(1);
      end
      if (scan_end) pend_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/bcps_cell.sv -----
// ---------------------------------------------------------------------------
// bcps_cell
// One slot: stores a box and tests the probe box passing through it.
// ---------------------------------------------------------------------------
module bcps_cell import bcps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  box_t       wr_box,
  input  logic       shift,
  input  probe_t     probe_in,
  input  logic [8:0] matrix,
  input  logic       occupied,
  output box_t       box,
  output probe_t     probe_out,
  output hit_t       hit
);

  probe_t probe;
  logic   act, na, nb;

  always_ff @(posedge clk) begin
    if (wr) box <= wr_box;
    if (rst) begin
      probe.valid <= 1'b0;
    end else if (shift) begin
      probe <= probe_in;
    end
  end

  always_comb begin
    act = probe.valid && occupied;
    na  = reports(matrix, probe.box.ctype, box.ctype) && probe.box.listener;
    nb  = reports(matrix, box.ctype, probe.box.ctype) && box.listener;
    hit.hit = act && overlap(probe.box, box) && (na || nb);
    hit.na  = act && na;
    hit.nb  = act && nb;
  end

  assign probe_out = probe;

endmodule

// ----- bench/box_collision_pair_scanner_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_collision_pair_scanner_unit_tb
// Drives add, mark, clear and frame items into the box table with random
// idling on both channels, predicts every result item from a behavioral
// copy of the table and matrix, and checks result items field by field in
// order. The notify matrix is changed between phases while the block is idle.
// ---------------------------------------------------------------------------
module box_collision_pair_scanner_unit_tb import bcps_pkg::*;;

  localparam int NSLOT = DEFAULT_NUM_SLOTS;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wen = 1'b0;
  logic [8:0] cfg_wdata = '0;

  box_collision_pair_scanner_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // table shadow
  logic [8:0] matrix_q;
  logic tbl_valid[NSLOT];
  logic tbl_doomed[NSLOT];
  box_t tbl_box[NSLOT];

  function automatic logic type_reports(logic [8:0] m, logic [1:0] a, logic [1:0] b);
    int bit_no;
    if (a > 2 || b > 2) return 1'b0;
    bit_no = a * 3 + b;
    return m[bit_no];
  endfunction

  function automatic logic boxes_touch(box_t p, box_t q);
    int pl, pt, pr, pb, ql, qt, qr, qb;
    pl = p.x; pt = p.y; pr = pl + int'(p.w); pb = pt + int'(p.h);
    ql = q.x; qt = q.y; qr = ql + int'(q.w); qb = qt + int'(q.h);
    return !(qr < pl || qb < pt || ql > pr || qt > pb);
  endfunction

  function automatic out_item_t mk_result(logic [2:0] k, logic [2:0] a, logic [2:0] b,
                                          logic na, logic nb, logic lst);
    out_item_t r;
    r.kind = k; r.first_slot = a; r.second_slot = b;
    r.notify_first = na; r.notify_second = nb; r.last = lst;
    return r;
  endfunction

  task automatic predict_scan(input in_item_t it);
    int n;
    logic na, nb;
    logic placed;
    n = 0;
    placed = 1'b0;
    case (it.func)
      FUNC_ADD: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!placed && !tbl_valid[i]) begin
            placed = 1'b1;
            tbl_valid[i] = 1'b1;
            tbl_doomed[i] = 1'b0;
            tbl_box[i].x = it.rect_x; tbl_box[i].y = it.rect_y;
            tbl_box[i].w = it.rect_w; tbl_box[i].h = it.rect_h;
            tbl_box[i].ctype = it.box_type;
            tbl_box[i].listener = it.has_listener;
            expected_results.push_back(mk_result(KIND_ASSIGNED, 3'(i), 3'd0,
                                                 1'b0, 1'b0, 1'b1));
          end
        end
        if (!placed)
          expected_results.push_back(mk_result(KIND_FULL, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1));
      end
      FUNC_MARK: begin
        if (tbl_valid[it.slot_index]) tbl_doomed[it.slot_index] = 1'b1;
        expected_results.push_back(mk_result(KIND_ACK, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1));
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) begin
          tbl_valid[i] = 1'b0; tbl_doomed[i] = 1'b0;
        end
        expected_results.push_back(mk_result(KIND_ACK, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1));
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_doomed[i]) tbl_valid[i] = 1'b0;
          tbl_doomed[i] = 1'b0;
        end
        for (int i = 0; i < NSLOT; i++)
          for (int j = i + 1; j < NSLOT; j++)
            if (tbl_valid[i] && tbl_valid[j] && n < MAX_RESULTS &&
                boxes_touch(tbl_box[i], tbl_box[j])) begin
              na = type_reports(matrix_q, tbl_box[i].ctype, tbl_box[j].ctype)
                   && tbl_box[i].listener;
              nb = type_reports(matrix_q, tbl_box[j].ctype, tbl_box[i].ctype)
                   && tbl_box[j].listener;
              if (na || nb) begin
                expected_results.push_back(mk_result(KIND_PAIR, 3'(i), 3'(j), na, nb,
                                                     1'b0));
                n++;
              end
            end
        if (n == 0)
          expected_results.push_back(mk_result(KIND_DONE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1));
        else expected_results[$].last = 1'b1;
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_scan(in_item);
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item kind=%0d", out_item.kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_item.kind); fail_count++;
          end
          if (out_item.first_slot !== want.first_slot) begin
            $error("first_slot: expected %0d, got %0d", want.first_slot,
                   out_item.first_slot); fail_count++;
          end
          if (out_item.second_slot !== want.second_slot) begin
            $error("second_slot: expected %0d, got %0d", want.second_slot,
                   out_item.second_slot); fail_count++;
          end
          if (out_item.notify_first !== want.notify_first) begin
            $error("notify_first: expected %0d, got %0d", want.notify_first,
                   out_item.notify_first); fail_count++;
          end
          if (out_item.notify_second !== want.notify_second) begin
            $error("notify_second: expected %0d, got %0d", want.notify_second,
                   out_item.notify_second); fail_count++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_item.last); fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic [1:0] f);
    in_item_t it;
    it = '0;
    it.func = f;
    return it;
  endfunction

  function automatic in_item_t mk_add(int x, int y, int w, int h, int t, int l);
    in_item_t it;
    it = mk_item(FUNC_ADD);
    it.rect_x = 16'(x); it.rect_y = 16'(y); it.rect_w = 15'(w); it.rect_h = 15'(h);
    it.box_type = 2'(t); it.has_listener = 1'(l);
    return it;
  endfunction

  function automatic in_item_t rand_add();
    in_item_t it;
    if ($urandom_range(9) == 0) begin
      it = mk_add($urandom, $urandom, $urandom, $urandom, $urandom_range(3), $urandom_range(1));
    end else begin
      it = mk_add($signed($urandom_range(400)) - 200, $signed($urandom_range(400)) - 200,
                  $urandom_range(150), $urandom_range(150), $urandom_range(3),
                  $urandom_range(1));
    end
    it.slot_index = 3'($urandom);
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_matrix(logic [8:0] m);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_wen <= 1'b0;
    matrix_q = m;
  endtask

  task automatic random_phase(int count);
    in_item_t it;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 50) it = rand_add();
      else if (r < 70) begin
        it = mk_item(FUNC_MARK); it.slot_index = 3'($urandom);
        it.rect_x = 16'($urandom);
      end else if (r < 92) it = mk_item(FUNC_FRAME);
      else it = mk_item(FUNC_CLEAR);
      pending_items.push_back(it);
    end
  endtask

  initial begin
    in_item_t it;
    matrix_q = MATRIX_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 1'b0; tbl_doomed[i] = 1'b0; tbl_box[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed
    write_matrix(9'h1FF);
    pending_items.push_back(mk_item(FUNC_FRAME));
    pending_items.push_back(mk_add(-32768, -32768, 32767, 32767, 2, 1));
    pending_items.push_back(mk_add(32767, 32767, 32767, 32767, 1, 1));
    pending_items.push_back(mk_add(-1, -1, 0, 0, 0, 0));
    pending_items.push_back(mk_add(10, 10, 5, 5, 3, 1));
    pending_items.push_back(mk_add(15, 15, 0, 0, 2, 1));
    pending_items.push_back(mk_add(16, 16, 1, 1, 1, 0));
    pending_items.push_back(mk_add(0, 0, 100, 100, 2, 1));
    pending_items.push_back(mk_add(-1, 0, 1, 1, 1, 1));
    pending_items.push_back(mk_add(5, 5, 5, 5, 2, 1));
    pending_items.push_back(mk_item(FUNC_FRAME));
    it = mk_item(FUNC_MARK); it.slot_index = 3'd7; pending_items.push_back(it);
    pending_items.push_back(it);
    it.slot_index = 3'd2; pending_items.push_back(it);
    pending_items.push_back(mk_add(1, 1, 1, 1, 2, 1));
    pending_items.push_back(mk_item(FUNC_FRAME));
    it.slot_index = 3'd7; pending_items.push_back(it);
    pending_items.push_back(mk_item(FUNC_FRAME));
    pending_items.push_back(mk_item(FUNC_CLEAR));
    pending_items.push_back(mk_item(FUNC_FRAME));
    wait_drained();

    write_matrix(9'd0);
    for (int k = 0; k < 6; k++) pending_items.push_back(rand_add());
    pending_items.push_back(mk_item(FUNC_FRAME));
    pending_items.push_back(mk_item(FUNC_CLEAR));
    wait_drained();

    send_idle_pct = 23; recv_idle_pct = 79;
    write_matrix(MATRIX_RESET);
    random_phase(25);
    wait_drained();

    send_idle_pct = 79; recv_idle_pct = 23;
    write_matrix(9'($urandom));
    random_phase(25);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_matrix(9'h1FF);
    random_phase(25);
    wait_drained();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
